// ===== hdl/rgb2hsl_pkg.sv =====
// Package with the shared types, constants and divider step functions of the RGB to HSL converter.
package rgb2hsl_pkg;

    localparam int QBITS      = 17;
    localparam int SAT_W      = 9;
    localparam int HUE_W      = 12;
    localparam int SAT_NW     = SAT_W + QBITS;
    localparam int HUE_NW     = HUE_W + QBITS;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = 2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha_in;
    } pixel_t;

    typedef struct packed {
        logic [15:0] hue;
        logic [15:0] saturation;
        logic [15:0] lightness;
        logic [7:0]  alpha_out;
    } hsl_t;

    typedef enum logic [2:0] {
        MAX_RED   = 3'b001,
        MAX_GREEN = 3'b010,
        MAX_BLUE  = 3'b100
    } max_chan_t;

    // Work request handed from the front to the back.
    typedef struct packed {
        logic [HUE_NW-1:0] hue_x;
        logic [HUE_W-1:0]  hue_d;
        logic [SAT_NW-1:0] sat_x;
        logic [SAT_W-1:0]  sat_d;
        logic [15:0]       lightness;
        logic [7:0]        alpha;
        logic              achromatic;
    } work_t;

    // One restoring division step: the remainder sits above the remaining numerator bits.
    function automatic logic [SAT_NW-1:0] sat_step(input logic [SAT_NW-1:0] x,
                                                   input logic [SAT_W-1:0] d);
        logic [SAT_W:0]   t;
        logic [SAT_W:0]   diff;
        logic             ge;
        logic [SAT_W-1:0] hi;
        t    = x[SAT_NW-1:QBITS-1];
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        hi   = ge ? diff[SAT_W-1:0] : t[SAT_W-1:0];
        return {hi, x[QBITS-2:0], ge};
    endfunction

    function automatic logic [HUE_NW-1:0] hue_step(input logic [HUE_NW-1:0] x,
                                                   input logic [HUE_W-1:0] d);
        logic [HUE_W:0]   t;
        logic [HUE_W:0]   diff;
        logic             ge;
        logic [HUE_W-1:0] hi;
        t    = x[HUE_NW-1:QBITS-1];
        diff = t - {1'b0, d};
        ge   = (t >= {1'b0, d});
        hi   = ge ? diff[HUE_W-1:0] : t[HUE_W-1:0];
        return {hi, x[QBITS-2:0], ge};
    endfunction

endpackage

// ===== hdl/rgb2hsl_front.sv =====
// Front stage: finds max and min, classifies the pixel and forms dividends and divisors.
module rgb2hsl_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    output logic                 full,
    input  rgb2hsl_pkg::pixel_t  pixel,
    output logic                 work_valid,
    input  logic                 work_full,
    output rgb2hsl_pkg::work_t   work
);

    logic                   valid_reg;
    rgb2hsl_pkg::work_t     work_reg;
    rgb2hsl_pkg::work_t     work_next;
    rgb2hsl_pkg::max_chan_t chan;
    logic [7:0]             mx;
    logic [7:0]             mn;
    logic [7:0]             d;
    logic [8:0]             sum;
    logic [8:0]             den;
    logic [11:0]            num;
    logic [10:0]            six_d;
    logic [16:0]            sum257;
    logic                   take;

    assign take = !valid_reg || !work_full;
    assign full = !take;

    always_comb
    begin
        if (pixel.red >= pixel.green && pixel.red >= pixel.blue)
        begin
            chan = rgb2hsl_pkg::MAX_RED;
        end
        else if (pixel.green >= pixel.blue)
        begin
            chan = rgb2hsl_pkg::MAX_GREEN;
        end
        else
        begin
            chan = rgb2hsl_pkg::MAX_BLUE;
        end

        mn = pixel.red;
        if (pixel.green < mn)
        begin
            mn = pixel.green;
        end
        if (pixel.blue < mn)
        begin
            mn = pixel.blue;
        end

        case (chan)
            rgb2hsl_pkg::MAX_RED:   mx = pixel.red;
            rgb2hsl_pkg::MAX_GREEN: mx = pixel.green;
            default:                mx = pixel.blue;
        endcase

        d     = mx - mn;
        sum   = {1'b0, mx} + {1'b0, mn};
        den   = (sum > 9'd255) ? (9'd510 - sum) : sum;
        six_d = ({3'b0, d} << 2) + ({3'b0, d} << 1);

        case (chan)
            rgb2hsl_pkg::MAX_RED:
            begin
                if (pixel.green >= pixel.blue)
                begin
                    num = {4'b0, pixel.green} - {4'b0, pixel.blue};
                end
                else
                begin
                    num = {1'b0, six_d} + {4'b0, pixel.green} - {4'b0, pixel.blue};
                end
            end
            rgb2hsl_pkg::MAX_GREEN:
                num = {4'b0, pixel.blue} + {3'b0, d, 1'b0} - {4'b0, pixel.red};
            default:
                num = {4'b0, pixel.red} + {2'b0, d, 2'b0} - {4'b0, pixel.green};
        endcase

        sum257 = {sum, 8'b0} + {8'b0, sum} + 17'd1;

        work_next.hue_x      = {num, 17'b0} + {18'b0, six_d};
        work_next.hue_d      = {1'b0, d, 3'b0} + {2'b0, d, 2'b0};
        work_next.sat_x      = ({1'b0, d, 17'b0} - {17'b0, d, 1'b0}) + {17'b0, den};
        work_next.sat_d      = {den[7:0], 1'b0};
        work_next.lightness  = sum257[16:1];
        work_next.alpha      = pixel.alpha_in;
        work_next.achromatic = (d == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= push;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && push)
        begin
            work_reg <= work_next;
        end
    end

    assign work_valid = valid_reg;
    assign work       = work_reg;

endmodule

// ===== hdl/rgb2hsl_queue.sv =====
// Short queue of work requests between the front and the back.
module rgb2hsl_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  rgb2hsl_pkg::work_t  wr_data,
    output logic                q_full,
    input  logic                rd_en,
    output logic                q_empty,
    output rgb2hsl_pkg::work_t  rd_data
);

    rgb2hsl_pkg::work_t                mem [rgb2hsl_pkg::QDEPTH];
    logic [rgb2hsl_pkg::QPTR_W-1:0]    wr_ptr_reg;
    logic [rgb2hsl_pkg::QPTR_W-1:0]    rd_ptr_reg;
    logic [rgb2hsl_pkg::QPTR_W:0]      count_reg;
    logic                              do_wr;
    logic                              do_rd;

    assign q_full  = (count_reg == (rgb2hsl_pkg::QPTR_W+1)'(rgb2hsl_pkg::QDEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_rd && !do_wr)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== hdl/rgb2hsl_back.sv =====
// Back part: two pipelined restoring dividers, one quotient bit per stage, and the result register.
module rgb2hsl_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  rgb2hsl_pkg::work_t  q_data,
    output logic                q_pop,
    output logic                empty,
    input  logic                pop,
    output rgb2hsl_pkg::hsl_t   result
);

    logic               st_v_reg [rgb2hsl_pkg::QBITS+1];
    rgb2hsl_pkg::work_t st_reg   [rgb2hsl_pkg::QBITS+1];
    rgb2hsl_pkg::work_t st_next  [rgb2hsl_pkg::QBITS+1];
    rgb2hsl_pkg::work_t last;
    logic               advance;

    assign advance = !st_v_reg[rgb2hsl_pkg::QBITS] || pop;
    assign q_pop   = advance && !q_empty;

    always_comb
    begin
        st_next[0] = q_data;
        for (int k = 1; k <= rgb2hsl_pkg::QBITS; k++)
        begin
            st_next[k]       = st_reg[k-1];
            st_next[k].hue_x = rgb2hsl_pkg::hue_step(st_reg[k-1].hue_x, st_reg[k-1].hue_d);
            st_next[k].sat_x = rgb2hsl_pkg::sat_step(st_reg[k-1].sat_x, st_reg[k-1].sat_d);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= rgb2hsl_pkg::QBITS; k++)
            begin
                st_v_reg[k] <= 1'b0;
            end
        end
        else if (advance)
        begin
            st_v_reg[0] <= !q_empty;
            for (int k = 1; k <= rgb2hsl_pkg::QBITS; k++)
            begin
                st_v_reg[k] <= st_v_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k <= rgb2hsl_pkg::QBITS; k++)
            begin
                st_reg[k] <= st_next[k];
            end
        end
    end

    assign last  = st_reg[rgb2hsl_pkg::QBITS];
    assign empty = !st_v_reg[rgb2hsl_pkg::QBITS];

    always_comb
    begin
        result.hue        = last.achromatic ? 16'd0 : last.hue_x[15:0];
        result.saturation = last.achromatic ? 16'd0 : last.sat_x[15:0];
        result.lightness  = last.lightness;
        result.alpha_out  = last.alpha;
    end

endmodule

// ===== hdl/rgb_to_hsl_converter_unit.sv =====
// Top level of the RGB to HSL converter: front, work queue and divider back end.
// An accepted request passes the front register, the work queue and the divider stages before its result shows.
// Throughput: one pixel per cycle while results are popped; the 17-stage divider pipeline advances only when not held.
// Reset: rst_n clears all valid flags and queue pointers at once; payload is not reset.
// After reset the block is empty and accepts a request in the first cycle.
module rgb_to_hsl_converter_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    output logic                full,
    input  rgb2hsl_pkg::pixel_t pixel,
    output logic                empty,
    input  logic                pop,
    output rgb2hsl_pkg::hsl_t   result
);

    // The front registers one request, computing max, min and the two dividend and divisor
    // pairs. It stalls only when the queue is full.
    logic               work_valid;
    logic               work_full;
    rgb2hsl_pkg::work_t work;
    logic               q_empty;
    logic               q_pop;
    rgb2hsl_pkg::work_t q_data;

    rgb2hsl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .pixel      (pixel),
        .work_valid (work_valid),
        .work_full  (work_full),
        .work       (work)
    );

    // The queue lets the front keep taking requests while the back is held, up to four waiting requests.
    rgb2hsl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (work_valid),
        .wr_data (work),
        .q_full  (work_full),
        .rd_en   (q_pop),
        .q_empty (q_empty),
        .rd_data (q_data)
    );

    // The back runs hue and saturation through rounding divisions, one quotient bit per
    // stage, and holds the finished result in its last stage until it is popped.
    rgb2hsl_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .empty   (empty),
        .pop     (pop),
        .result  (result)
    );

endmodule

// ===== hdl/rgb2hsl_checker.sv =====
// Port checker for the RGB to HSL converter and its bind to the top level.
module rgb2hsl_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                empty,
    input logic                pop,
    input rgb2hsl_pkg::hsl_t   result
);

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("waiting result changed or vanished");

    a_gray_hue: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.saturation == 16'd0) |-> (result.hue == 16'd0))
        else $error("hue nonzero for achromatic pixel");

    a_black_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.lightness == 16'd0) |-> (result.saturation == 16'd0))
        else $error("saturation nonzero for black pixel");

    a_white_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.lightness == 16'hFFFF) |-> (result.saturation == 16'd0))
        else $error("saturation nonzero for white pixel");

endmodule

bind rgb_to_hsl_converter_unit rgb2hsl_checker u_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .empty  (empty),
    .pop    (pop),
    .result (result)
);
